// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the splitter RTL files.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BTS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("bts assertion failed");

// Checks that a condition never holds outside reset.
`define BTS_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("bts forbidden condition seen");

`endif

// ===== rtl/core/bts_pkg.sv =====
// Shared types and constants of the backtick record splitter.
// Depends on nothing; imported by every module of the block.
package bts_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned CFG_ADDR_W   = 3;

  localparam logic [15:0] CH_TICK = 16'h0060;
  localparam logic [15:0] CH_LF   = 16'h000A;
  localparam logic [15:0] CH_CR   = 16'h000D;
  localparam logic [15:0] CH_TAB  = 16'h0009;
  localparam logic [15:0] CH_SP   = 16'h0020;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_ID      = 2'd0,
    EV_CONTENT = 2'd1,
    EV_STATUS  = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_START = 2'd1,
    ERR_NO_ID     = 2'd2
  } error_code_e;

  // Results caused by one input word, given out in the order span, empty
  // content, status.
  typedef struct packed {
    logic        has_span;
    logic        has_empty;
    logic        has_status;
    event_kind_e span_kind;
    logic [15:0] span_begin;
    logic [15:0] span_length;
    error_code_e err;
    logic [15:0] row;
    logic [15:0] column;
    logic [15:0] pos;
  } group_t;

endpackage

// ===== rtl/core/bts_front.sv =====
// Front part of the splitter: classifies each character and keeps the parse state.
// Depends on bts_pkg and assert_macros.svh; feeds result groups to bts_queue.
`include "assert_macros.svh"

module bts_front import bts_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char16_i,
  input  logic        accept_i,
  input  logic [15:0] char_code_i,
  input  logic        end_of_data_i,
  output logic        push_o,
  output group_t      group_o
);

  logic                expecting_q, expecting_d;
  logic                comment_q, comment_d;
  error_code_e         err_q, err_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic                valid_q, valid_d;
  logic [POS_BITS-1:0] stop_q, stop_d;
  logic [15:0]         prev_q, prev_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [15:0]         row_q, row_d;
  logic [15:0]         col_q, col_d;

  logic [15:0]         c;
  logic                crlf, eol, halted;
  logic [POS_BITS:0]   pos_sum;

  always_comb begin
    c       = char16_i ? char_code_i : {8'h00, char_code_i[7:0]};
    crlf    = (c == CH_LF) && (prev_q == CH_CR);
    eol     = (c == CH_LF) || (c == CH_CR);
    pos_sum = {1'b0, pos_q} + (char16_i ? (POS_BITS+1)'(2) : (POS_BITS+1)'(1));
  end

  always_comb begin
    expecting_d = expecting_q;
    comment_d   = comment_q;
    err_d       = err_q;
    start_d     = start_q;
    valid_d     = valid_q;
    stop_d      = stop_q;
    prev_d      = prev_q;
    pos_d       = pos_q;
    row_d       = row_q;
    col_d       = col_q;
    halted      = 1'b0;
    push_o      = 1'b0;
    group_o            = '0;
    group_o.span_kind  = EV_ID;
    group_o.err        = ERR_NONE;
    group_o.row        = row_q;
    group_o.column     = col_q;
    group_o.pos        = 16'(pos_q);

    if (accept_i && end_of_data_i) begin
      push_o             = 1'b1;
      group_o.has_status = 1'b1;
      group_o.err        = err_q;
      if (err_q == ERR_NONE) begin
        if (expecting_q) begin
          if (!valid_q) begin
            group_o.err = ERR_NO_ID;
          end else begin
            group_o.has_span    = 1'b1;
            group_o.has_empty   = 1'b1;
            group_o.span_kind   = EV_ID;
            group_o.span_begin  = 16'(start_q);
            group_o.span_length = 16'(pos_q - start_q);
          end
        end else begin
          group_o.has_span  = 1'b1;
          group_o.span_kind = EV_CONTENT;
          if (valid_q && (pos_q > start_q)) begin
            group_o.span_begin  = 16'(start_q);
            group_o.span_length = 16'(pos_q - start_q);
          end
        end
      end
      expecting_d = 1'b1;
      comment_d   = 1'b0;
      err_d       = ERR_NONE;
      start_d     = '0;
      valid_d     = 1'b0;
      stop_d      = '0;
      prev_d      = '0;
      pos_d       = '0;
      row_d       = '0;
      col_d       = '0;
    end else if (accept_i && (err_q == ERR_NONE)) begin
      if (!comment_q) begin
        if (expecting_q) begin
          if (col_q == 16'd0) begin
            if (!eol && (c != CH_TICK)) begin
              err_d  = ERR_BAD_START;
              halted = 1'b1;
            end
          end else if (crlf) begin
            halted = 1'b0;
          end else if (eol) begin
            if (!valid_q) begin
              err_d  = ERR_NO_ID;
              halted = 1'b1;
            end else begin
              push_o              = 1'b1;
              group_o.has_span    = 1'b1;
              group_o.span_kind   = EV_ID;
              group_o.span_begin  = 16'(start_q);
              group_o.span_length = 16'(pos_q - start_q);
              expecting_d         = 1'b0;
              valid_d             = 1'b0;
              start_d             = '0;
              stop_d              = '0;
            end
          end else if ((c == CH_SP) || (c == CH_TAB)) begin
            halted = 1'b0;
          end else if ((c == CH_TICK) && (prev_q == CH_TICK)) begin
            valid_d   = 1'b0;
            start_d   = '0;
            stop_d    = '0;
            comment_d = 1'b1;
          end else if (!valid_q) begin
            valid_d = 1'b1;
            start_d = pos_q;
          end
        end else begin
          if (crlf) begin
            halted = 1'b0;
          end else if (eol) begin
            if (col_q != 16'd0) begin
              stop_d = pos_q;
            end
          end else if (c == CH_TICK) begin
            if (col_q == 16'd0) begin
              push_o            = 1'b1;
              group_o.has_span  = 1'b1;
              group_o.span_kind = EV_CONTENT;
              if (valid_q && (stop_q > start_q)) begin
                group_o.span_begin  = 16'(start_q);
                group_o.span_length = 16'(stop_q - start_q);
              end
              expecting_d = 1'b1;
              valid_d     = 1'b0;
              start_d     = '0;
              stop_d      = '0;
            end
          end else if (!valid_q) begin
            valid_d = 1'b1;
            start_d = pos_q;
          end
        end
      end

      if (!halted) begin
        if (crlf) begin
          col_d = col_q;
        end else if (eol) begin
          comment_d = 1'b0;
          col_d     = '0;
          if (row_q != CNT_MAX) begin
            row_d = row_q + 16'd1;
          end
        end else if (col_q != CNT_MAX) begin
          col_d = col_q + 16'd1;
        end
        prev_d = c;
        pos_d  = pos_sum[POS_BITS] ? {POS_BITS{1'b1}} : pos_sum[POS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expecting_q <= 1'b1;
      comment_q   <= 1'b0;
      err_q       <= ERR_NONE;
      start_q     <= '0;
      valid_q     <= 1'b0;
      stop_q      <= '0;
      prev_q      <= '0;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      expecting_q <= expecting_d;
      comment_q   <= comment_d;
      err_q       <= err_d;
      start_q     <= start_d;
      valid_q     <= valid_d;
      stop_q      <= stop_d;
      prev_q      <= prev_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
    end
  end

  `BTS_ASSERT(a_error_freezes_position, clk_i, rst_ni,
    (err_q != ERR_NONE) && !(accept_i && end_of_data_i) |=> $stable(pos_q))
  `BTS_ASSERT(a_stream_end_reports, clk_i, rst_ni,
    accept_i && end_of_data_i |-> push_o && group_o.has_status)

endmodule

// ===== rtl/core/bts_queue.sv =====
// Short queue of result groups between the front and the output stage.
// Depends on bts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bts_queue import bts_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  group_t data_i,
  input  logic   pop_i,
  output group_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  group_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `BTS_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && full_o)

endmodule

// ===== rtl/core/bts_back.sv =====
// Output stage: unpacks a result group into single result words, one per pop.
// Depends on bts_pkg and assert_macros.svh; takes groups from bts_queue.
`include "assert_macros.svh"

module bts_back import bts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  group_t      head_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  event_kind_o,
  output logic [15:0] span_begin_o,
  output logic [15:0] span_length_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] row_count_o,
  output logic [15:0] column_count_o,
  output logic [15:0] byte_position_o,
  output logic        last_of_run_o
);

  group_t cur_q, cur_d;
  logic   live, take;

  assign live  = cur_q.has_span || cur_q.has_empty || cur_q.has_status;
  assign empty = !live;
  assign take  = pop && live;

  always_comb begin
    cur_d   = cur_q;
    q_pop_o = 1'b0;
    if (take) begin
      if (cur_q.has_span) begin
        cur_d.has_span = 1'b0;
      end else if (cur_q.has_empty) begin
        cur_d.has_empty = 1'b0;
      end else begin
        cur_d.has_status = 1'b0;
      end
    end
    if (!(cur_d.has_span || cur_d.has_empty || cur_d.has_status) && !q_empty_i) begin
      cur_d   = head_i;
      q_pop_o = 1'b1;
    end
  end

  always_comb begin
    row_count_o     = cur_q.row;
    column_count_o  = cur_q.column;
    byte_position_o = cur_q.pos;
    if (cur_q.has_span) begin
      event_kind_o  = cur_q.span_kind;
      span_begin_o  = cur_q.span_begin;
      span_length_o = cur_q.span_length;
      error_code_o  = ERR_NONE;
      last_of_run_o = 1'b0;
    end else if (cur_q.has_empty) begin
      event_kind_o  = EV_CONTENT;
      span_begin_o  = '0;
      span_length_o = '0;
      error_code_o  = ERR_NONE;
      last_of_run_o = 1'b0;
    end else begin
      event_kind_o  = EV_STATUS;
      span_begin_o  = '0;
      span_length_o = '0;
      error_code_o  = cur_q.err;
      last_of_run_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  `BTS_ASSERT(a_span_has_no_error, clk_i, rst_ni,
    !empty && (event_kind_o != EV_STATUS) |-> (error_code_o == ERR_NONE) && !last_of_run_o)

endmodule

// ===== rtl/core/backtick_record_splitter_core.sv =====
// Top level of the backtick record splitter: configuration port and wiring.
// Depends on bts_pkg, bts_front, bts_queue and bts_back.

// The block takes one character word per clock on the push side while full is
// low, with no gaps needed between words, and splits the stream into ID spans,
// content spans and a closing status word. A character causes at most one
// result; an end-of-data word causes up to three (ID span, empty content and
// status, or content and status, or the status alone after an error), handed
// out one per pop. The front classifies each character combinationally, so one
// word is taken per clock while full is low; with the result side idle, a
// word's first result goes into the queue, then into the output stage register
// that drives the result ports. Result groups wait in a four-entry queue, and
// the output stage holds one more group, so push stalls through full only when
// five groups are left untaken. char_is_16bit sits at byte address 0 of the
// configuration port and should be changed only while the block is idle.
module backtick_record_splitter_core import bts_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [15:0]           char_code_i,
  input  logic                  end_of_data_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            event_kind_o,
  output logic [15:0]           span_begin_o,
  output logic [15:0]           span_length_o,
  output logic [1:0]            error_code_o,
  output logic [15:0]           row_count_o,
  output logic [15:0]           column_count_o,
  output logic [15:0]           byte_position_o,
  output logic                  last_of_run_o
);

  logic   char16_q;
  logic   reg_hit;
  logic   accept;
  logic   front_push;
  group_t front_group;
  group_t q_head;
  logic   q_empty, q_pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == '0);
  assign prdata  = reg_hit ? {31'b0, char16_q} : 32'b0;
  assign accept  = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char16_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      char16_q <= pwdata[0];
    end
  end

  bts_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char16_i     (char16_q),
    .accept_i     (accept),
    .char_code_i  (char_code_i),
    .end_of_data_i(end_of_data_i),
    .push_o       (front_push),
    .group_o      (front_group)
  );

  bts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_group),
    .pop_i  (q_pop),
    .head_o (q_head),
    .full_o (full),
    .empty_o(q_empty)
  );

  bts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .event_kind_o   (event_kind_o),
    .span_begin_o   (span_begin_o),
    .span_length_o  (span_length_o),
    .error_code_o   (error_code_o),
    .row_count_o    (row_count_o),
    .column_count_o (column_count_o),
    .byte_position_o(byte_position_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ===== tb/sv/split_event_checker.sv =====
`timescale 1ns / 1ps
// Checker for the backtick record splitter: watches the character, result and
// configuration channels, predicts every result word and compares it.
// Depends on bts_pkg for the event and error codes and the character constants.
module split_event_checker import bts_pkg::*; #(
  parameter logic [CFG_ADDR_W-1:0] WIDTH_REG_ADDR = '0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  push,
  input  logic                  full,
  input  logic [15:0]           char_code_i,
  input  logic                  end_of_data_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [1:0]            kind_i,
  input  logic [15:0]           begin_i,
  input  logic [15:0]           length_i,
  input  logic [1:0]            err_i,
  input  logic [15:0]           row_i,
  input  logic [15:0]           col_i,
  input  logic [15:0]           pos_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    event_kind_e kind;
    logic [15:0] span_begin;
    logic [15:0] span_length;
    error_code_e err;
    logic [15:0] row;
    logic [15:0] column;
    logic [15:0] pos;
    logic        last;
  } split_word_t;

  logic        wide;
  logic        want_id;
  logic        in_comment;
  error_code_e halt_err;
  logic        span_open;
  logic [15:0] span_first;
  logic [15:0] span_end;
  logic [15:0] prev_ch;
  logic [15:0] pos_cnt;
  logic [15:0] row_cnt;
  logic [15:0] col_cnt;

  split_word_t expected_words[$];
  split_word_t got_word;
  int          fails = 0;

  function automatic split_word_t form_word(event_kind_e kind, logic [15:0] first,
                                            logic [15:0] len, error_code_e err,
                                            logic last);
    split_word_t w;
    w.kind        = kind;
    w.span_begin  = first;
    w.span_length = len;
    w.err         = err;
    w.row         = row_cnt;
    w.column      = col_cnt;
    w.pos         = pos_cnt;
    w.last        = last;
    return w;
  endfunction

  task automatic drop_span();
    span_open  = 1'b0;
    span_first = '0;
    span_end   = '0;
  endtask

  task automatic restart_stream();
    want_id    = 1'b1;
    in_comment = 1'b0;
    halt_err   = ERR_NONE;
    drop_span();
    prev_ch    = '0;
    pos_cnt    = '0;
    row_cnt    = '0;
    col_cnt    = '0;
  endtask

  task automatic add_content(logic [15:0] stop);
    if (span_open && stop > span_first) begin
      expected_words.push_back(form_word(EV_CONTENT, span_first, stop - span_first,
                                         ERR_NONE, 1'b0));
    end else begin
      expected_words.push_back(form_word(EV_CONTENT, '0, '0, ERR_NONE, 1'b0));
    end
  endtask

  task automatic predict_word(logic [15:0] code, logic eod);
    logic [15:0] c;
    logic        crlf_tail;
    logic        eol;
    logic [16:0] next_pos;
    if (eod) begin
      if (halt_err == ERR_NONE) begin
        if (want_id) begin
          if (!span_open) begin
            halt_err = ERR_NO_ID;
          end else begin
            expected_words.push_back(form_word(EV_ID, span_first, pos_cnt - span_first,
                                               ERR_NONE, 1'b0));
            expected_words.push_back(form_word(EV_CONTENT, '0, '0, ERR_NONE, 1'b0));
          end
        end else begin
          add_content(pos_cnt);
        end
      end
      expected_words.push_back(form_word(EV_STATUS, '0, '0, halt_err, 1'b1));
      restart_stream();
      return;
    end
    if (halt_err != ERR_NONE) return;

    c         = wide ? code : {8'h00, code[7:0]};
    crlf_tail = (c == CH_LF) && (prev_ch == CH_CR);
    eol       = (c == CH_LF) || (c == CH_CR);

    if (!in_comment) begin
      if (want_id) begin
        if (col_cnt == 0) begin
          if (!eol && c != CH_TICK) begin
            halt_err = ERR_BAD_START;
            return;
          end
        end else if (eol) begin
          if (!crlf_tail) begin
            if (!span_open) begin
              halt_err = ERR_NO_ID;
              return;
            end
            expected_words.push_back(form_word(EV_ID, span_first, pos_cnt - span_first,
                                               ERR_NONE, 1'b0));
            want_id = 1'b0;
            drop_span();
          end
        end else if (c == CH_TICK && prev_ch == CH_TICK) begin
          drop_span();
          in_comment = 1'b1;
        end else if (!span_open && c != CH_SP && c != CH_TAB) begin
          span_open  = 1'b1;
          span_first = pos_cnt;
        end
      end else begin
        if (eol) begin
          if (!crlf_tail && col_cnt != 0) span_end = pos_cnt;
        end else if (c == CH_TICK) begin
          if (col_cnt == 0) begin
            add_content(span_end);
            want_id = 1'b1;
            drop_span();
          end
        end else if (!span_open) begin
          span_open  = 1'b1;
          span_first = pos_cnt;
        end
      end
    end

    if (eol && !crlf_tail) begin
      in_comment = 1'b0;
      col_cnt    = '0;
      if (row_cnt != CNT_MAX) row_cnt++;
    end else if (!eol && col_cnt != CNT_MAX) begin
      col_cnt++;
    end
    prev_ch  = c;
    next_pos = {1'b0, pos_cnt} + (wide ? 17'd2 : 17'd1);
    pos_cnt  = next_pos[16] ? 16'hFFFF : next_pos[15:0];
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide = 1'b0;
      restart_stream();
      expected_words.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: event_kind %0d", kind_i);
          fails++;
        end else begin
          got_word = expected_words.pop_front();
          check_field("event_kind", got_word.kind, kind_i);
          check_field("span_begin", got_word.span_begin, begin_i);
          check_field("span_length", got_word.span_length, length_i);
          check_field("error_code", got_word.err, err_i);
          check_field("row_count", got_word.row, row_i);
          check_field("column_count", got_word.column, col_i);
          check_field("byte_position", got_word.pos, pos_i);
          check_field("last_of_run", got_word.last, last_i);
        end
      end
      if (push && !full) predict_word(char_code_i, end_of_data_i);
      if (psel && penable && pwrite && pready && paddr == WIDTH_REG_ADDR) begin
        wide = pwdata[0];
      end
      pending_o    <= expected_words.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/sv/backtick_record_splitter_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the backtick record splitter testbench: clock, reset, stimulus and verdict.
// Depends on bts_pkg, backtick_record_splitter_core and split_event_checker.
module backtick_record_splitter_core_tb import bts_pkg::*;;

  localparam logic [CFG_ADDR_W-1:0] REG_CHAR_IS_16BIT = '0;
  localparam byte TICK_MARK   = "^";
  localparam int  HOLD_CYCLES = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  push;
  logic                  full;
  logic [15:0]           char_code;
  logic                  end_of_data;
  logic                  empty;
  logic                  pop;
  logic [1:0]            event_kind;
  logic [15:0]           span_begin;
  logic [15:0]           span_length;
  logic [1:0]            error_code;
  logic [15:0]           row_count;
  logic [15:0]           column_count;
  logic [15:0]           byte_position;
  logic                  last_of_run;
  int                    fail_count;
  int                    pending;

  logic wide_mode   = 1'b0;
  logic tx_jitter   = 1'b1;
  logic rx_jitter   = 1'b1;
  int   hold_req    = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   words_sent  = 0;
  int   streams_sent = 0;
  int   target;

  backtick_record_splitter_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code),
    .end_of_data_i  (end_of_data),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind),
    .span_begin_o   (span_begin),
    .span_length_o  (span_length),
    .error_code_o   (error_code),
    .row_count_o    (row_count),
    .column_count_o (column_count),
    .byte_position_o(byte_position),
    .last_of_run_o  (last_of_run)
  );

  split_event_checker #(
    .WIDTH_REG_ADDR(REG_CHAR_IS_16BIT)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code),
    .end_of_data_i(end_of_data),
    .empty        (empty),
    .pop          (pop),
    .kind_i       (event_kind),
    .begin_i      (span_begin),
    .length_i     (span_length),
    .err_i        (error_code),
    .row_i        (row_count),
    .col_i        (column_count),
    .pos_i        (byte_position),
    .last_i       (last_of_run),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(40_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random pop gaps, plus one long hold-off when requested.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= !(rx_jitter && $urandom_range(0, 99) < 8);
      end
    end
  end

  function automatic logic is_special(logic [15:0] c);
    return c == CH_LF || c == CH_CR || c == CH_TICK || c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic [15:0] ordinary_char();
    logic [15:0] c;
    do begin
      c = wide_mode ? 16'($urandom) : 16'($urandom_range(0, 255));
    end while (is_special(c));
    return c;
  endfunction

  function automatic logic [15:0] blank_char();
    return $urandom_range(0, 1) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [15:0] noise_char();
    logic [15:0] c;
    case ($urandom_range(0, 6))
      0:       c = CH_LF;
      1:       c = CH_CR;
      2:       c = CH_TICK;
      3:       c = CH_SP;
      4:       c = CH_TAB;
      default: c = 16'($urandom);
    endcase
    if ($urandom_range(0, 1)) c[15:8] = 8'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] content_char();
    case ($urandom_range(0, 5))
      4:       return blank_char();
      5:       return CH_TICK;
      default: return ordinary_char();
    endcase
  endfunction

  task automatic send_word(logic [15:0] c, logic eod);
    logic [15:0] word;
    word = c;
    if (eod) begin
      word = 16'($urandom);
    end else if (!wide_mode && $urandom_range(0, 1)) begin
      word[15:8] = 8'($urandom);
    end
    while (tx_jitter && $urandom_range(0, 99) < 8) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    char_code   <= word;
    end_of_data <= eod;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
    if (eod) streams_sent++;
  endtask

  task automatic send_text(string s);
    byte ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      send_word((ch == TICK_MARK) ? CH_TICK : {8'h00, ch}, 1'b0);
    end
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 2))
      0: send_word(CH_LF, 1'b0);
      1: send_word(CH_CR, 1'b0);
      default: begin
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
      end
    endcase
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_width(logic w);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CHAR_IS_16BIT;
    pwdata  <= {31'($urandom), w};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'($urandom);
    wide_mode = w;
  endtask

  // Mostly well-formed records with random content; the rest is noise.
  task automatic random_stream();
    int recs;
    int lines;
    int n;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(0, 8);
      repeat (n) send_word(noise_char(), 1'b0);
      send_word('0, 1'b1);
      return;
    end
    recs = $urandom_range(1, 4);
    for (int r = 0; r < recs; r++) begin
      if ($urandom_range(0, 9) == 0) send_eol();
      send_word(CH_TICK, 1'b0);
      if ($urandom_range(0, 9) == 0) begin
        send_word(CH_TICK, 1'b0);
        repeat ($urandom_range(0, 3)) send_word(ordinary_char(), 1'b0);
        send_eol();
        send_word(CH_TICK, 1'b0);
      end
      repeat ($urandom_range(0, 2)) send_word(blank_char(), 1'b0);
      repeat ($urandom_range(1, 4)) send_word(ordinary_char(), 1'b0);
      if (r == recs - 1 && $urandom_range(0, 6) == 0) break;
      send_eol();
      lines = $urandom_range(0, 3);
      for (int l = 0; l < lines; l++) begin
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) begin
          send_word((k == 0) ? ordinary_char() : content_char(), 1'b0);
        end
        if (!(r == recs - 1 && l == lines - 1 && $urandom_range(0, 2) == 0)) send_eol();
      end
    end
    send_word('0, 1'b1);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    push        <= 1'b0;
    char_code   <= '0;
    end_of_data <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_width(1'b0);
    send_text("^ \tid\r\nx\n\n^^\n^r");
    send_word('0, 1'b1);
    send_word('0, 1'b1);
    send_text("z^");
    send_word('0, 1'b1);
    send_text("^\n");
    send_word('0, 1'b1);
    send_text("^a\n");
    send_word('0, 1'b1);

    set_width(1'b1);
    target = words_sent + 180;
    random_stream();
    hold_req++;
    repeat (8) send_text("^a\n");
    send_word('0, 1'b1);
    while (words_sent < target) random_stream();

    set_width(1'b0);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    target = words_sent + 80;
    while (words_sent < target) random_stream();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    target = words_sent + 90;
    while (words_sent < target) random_stream();

    set_width(1'b1);
    repeat (2) random_stream();
    wait_idle();

    if (pending != 0) $error("%0d result words never arrived", pending);
    $display("Sent %0d words in %0d streams in both character widths, with comments,",
             words_sent, streams_sent);
    $display("CRLF, both errors, a stretch without idling and a %0d-cycle result stall.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
